### hw/rtl/gpcm_pkg.sv
// ----------------------------------------------------------------------------
// gpcm_pkg
// Shared types, widths, slot map and helpers of the ground plane camera mapper.
// ----------------------------------------------------------------------------
package gpcm_pkg;

   localparam int DATA_W = 32;
   localparam int PROD_W = 64;
   localparam int NSLOT  = 27;

   localparam int SLOT_R  = 0;
   localparam int SLOT_RI = 9;
   localparam int SLOT_T  = 18;
   localparam int SLOT_K  = 21;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_G2P  = 2'd1;
   localparam logic [1:0] MODE_P2W  = 2'd2;

   typedef logic [NSLOT-1:0][DATA_W-1:0] coef_set_type;

   localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(64'sd2147483647);
   localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(64'sd2147483648);

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[DATA_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[DATA_W-1:0];
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

### hw/rtl/gpcm_req_if.sv
// ----------------------------------------------------------------------------
// gpcm_req_if
// Input item channel: load, ground-to-pixel and pixel-to-world requests.
// ----------------------------------------------------------------------------
interface gpcm_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          mode;
   logic [4:0]          coef_index;
   logic signed [31:0]  coef_value;
   logic signed [31:0]  in_x;
   logic signed [31:0]  in_y;

   modport source (output valid, mode, coef_index, coef_value, in_x, in_y, input ready);
   modport sink   (input valid, mode, coef_index, coef_value, in_x, in_y, output ready);
endinterface

### hw/rtl/gpcm_rsp_if.sv
// ----------------------------------------------------------------------------
// gpcm_rsp_if
// Result item channel: mapped point and success flag.
// ----------------------------------------------------------------------------
interface gpcm_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  out_x;
   logic signed [31:0]  out_y;
   logic signed [31:0]  out_z;
   logic                ok;

   modport source (output valid, out_x, out_y, out_z, ok, input ready);
   modport sink   (input valid, out_x, out_y, out_z, ok, output ready);
endinterface

### hw/rtl/gpcm_coef_store.sv
// ----------------------------------------------------------------------------
// gpcm_coef_store
// Coefficient register file: one write port, slots read at fixed places.
// ----------------------------------------------------------------------------
module gpcm_coef_store #(
   parameter int COEF_DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              we,
   input  logic [4:0]                        waddr,
   input  logic [gpcm_pkg::DATA_W-1:0]       wdata,
   output gpcm_pkg::coef_set_type            coefs
);

   localparam int IDX_W = $clog2(COEF_DEPTH);

   logic [gpcm_pkg::DATA_W-1:0] store_ff [COEF_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COEF_DEPTH; i++) begin
            store_ff[i] <= '0;
         end
      end else if (we && (int'(waddr) < COEF_DEPTH)) begin
         store_ff[IDX_W'(waddr)] <= wdata;
      end
   end

   always_comb begin
      for (int i = 0; i < gpcm_pkg::NSLOT; i++) begin
         coefs[i] = store_ff[i];
      end
   end

endmodule

### hw/rtl/gpcm_div.sv
// ----------------------------------------------------------------------------
// gpcm_div
// Pipelined fixed point divider: (num << FRAC_BITS) / den, truncated toward
// zero and saturated; one quotient bit per stage, registered at both ends.
// ----------------------------------------------------------------------------
module gpcm_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [gpcm_pkg::DATA_W-1:0]   num,
   input  logic signed [gpcm_pkg::DATA_W-1:0]   den,
   output logic signed [gpcm_pkg::DATA_W-1:0]   quo
);

   localparam int DW = gpcm_pkg::DATA_W;
   localparam int NB = DW + FRAC_BITS;
   localparam int RW = DW + 1;
   localparam logic [NB-1:0] QMAX     = NB'({1'b0, {(DW-1){1'b1}}});
   localparam logic [NB-1:0] QMIN_MAG = NB'({1'b1, {(DW-1){1'b0}}});

   logic [RW-1:0] rem_ff  [NB+1];
   logic [NB-1:0] sh_ff   [NB+1];
   logic [DW-1:0] dmag_ff [NB+1];
   logic          sign_ff [NB+1];

   logic [DW-1:0] nmag_in;
   logic [DW-1:0] dmag_in;

   always_comb begin
      nmag_in = num[DW-1] ? DW'(-num) : DW'(num);
      dmag_in = den[DW-1] ? DW'(-den) : DW'(den);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= '0;
         sh_ff[0]   <= {nmag_in, {FRAC_BITS{1'b0}}};
         dmag_ff[0] <= dmag_in;
         sign_ff[0] <= num[DW-1] ^ den[DW-1];
      end
   end

   for (genvar k = 0; k < NB; k++) begin : g_step
      logic [RW-1:0] trial;
      logic [RW-1:0] rem_in;
      logic          bit_in;

      always_comb begin
         trial = {rem_ff[k][RW-2:0], sh_ff[k][NB-1]};
         if (trial >= {1'b0, dmag_ff[k]}) begin
            rem_in = trial - {1'b0, dmag_ff[k]};
            bit_in = 1'b1;
         end else begin
            rem_in = trial;
            bit_in = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_in;
            sh_ff[k+1]   <= {sh_ff[k][NB-2:0], bit_in};
            dmag_ff[k+1] <= dmag_ff[k];
            sign_ff[k+1] <= sign_ff[k];
         end
      end
   end

   logic signed [DW-1:0] quo_in;
   logic signed [DW-1:0] quo_ff;

   always_comb begin
      if (!sign_ff[NB]) begin
         quo_in = (sh_ff[NB] > QMAX) ? DW'(QMAX) : DW'(sh_ff[NB]);
      end else begin
         quo_in = (sh_ff[NB] >= QMIN_MAG) ? DW'(QMIN_MAG) : -DW'(sh_ff[NB]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

### hw/rtl/gpcm_delay.sv
// ----------------------------------------------------------------------------
// gpcm_delay
// Sideband shift line that keeps valid and tag data level with a divider.
// ----------------------------------------------------------------------------
module gpcm_delay #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 50
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [WIDTH-1:0]  in_data,
   output logic              out_valid,
   output logic [WIDTH-1:0]  out_data,
   output logic              busy
);

   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] data_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DEPTH-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= in_data;
         for (int k = 1; k < DEPTH; k++) begin
            data_ff[k] <= data_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];
   assign busy      = |valid_ff;

endmodule

### hw/rtl/ground_plane_camera_mapper.sv
// ----------------------------------------------------------------------------
// ground_plane_camera_mapper
// Pinhole camera mapping between ground plane and image, signed fixed point.
// ----------------------------------------------------------------------------
//   channel   dir   handshake      payload
//   req_chan  in    valid/ready    mode, coef_index, coef_value, in_x, in_y
//   rsp_chan  out   valid/ready    out_x, out_y, out_z, ok
//
// One item per cycle unless the result stalls; items pass two ranks of
// bit-per-stage dividers in series (Q16.16 by default). A load item waits at
// the input until no mapping item is in flight. Reset clears the coefficient
// store. A stalled result holds the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module ground_plane_camera_mapper #(
   parameter int COEF_DEPTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic       clock,
   input  logic       reset,
   gpcm_req_if.sink   req_chan,
   gpcm_rsp_if.source rsp_chan
);

   localparam int DW      = gpcm_pkg::DATA_W;
   localparam int PW      = gpcm_pkg::PROD_W;
   localparam int DIV_LAT = DW + FRAC_BITS + 2;
   localparam int RI      = gpcm_pkg::SLOT_RI;
   localparam int RR      = gpcm_pkg::SLOT_R;
   localparam int TT      = gpcm_pkg::SLOT_T;
   localparam int KK      = gpcm_pkg::SLOT_K;

   function automatic logic signed [PW-1:0] fmul(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
      logic signed [PW-1:0] p;
      p = PW'(a) * PW'(b);
      return p >>> FRAC_BITS;
   endfunction

   logic en;
   logic busy;
   logic accept;

   gpcm_pkg::coef_set_type coefs;
   logic signed [DW-1:0] cf [gpcm_pkg::NSLOT];

   always_comb begin
      for (int i = 0; i < gpcm_pkg::NSLOT; i++) begin
         cf[i] = coefs[i];
      end
   end

   assign accept = req_chan.valid && req_chan.ready;

   gpcm_coef_store #(.COEF_DEPTH(COEF_DEPTH)) u_store (
      .clock (clock),
      .reset (reset),
      .we    (accept && (req_chan.mode == gpcm_pkg::MODE_LOAD)),
      .waddr (req_chan.coef_index),
      .wdata (req_chan.coef_value),
      .coefs (coefs)
   );

   // stage A: rotation products and pixel offsets
   logic                 a_valid_in, a_valid_ff, a_p2w_in, a_p2w_ff;
   logic signed [PW-1:0] a_prod_in [6];
   logic signed [PW-1:0] a_prod_ff [6];
   logic signed [DW-1:0] a_dx_in, a_dx_ff, a_dy_in, a_dy_ff;

   always_comb begin
      a_valid_in = accept && ((req_chan.mode == gpcm_pkg::MODE_G2P) ||
                              (req_chan.mode == gpcm_pkg::MODE_P2W));
      a_p2w_in   = req_chan.mode == gpcm_pkg::MODE_P2W;
      for (int i = 0; i < 3; i++) begin
         a_prod_in[2*i]   = fmul(cf[RR+3*i],   req_chan.in_x);
         a_prod_in[2*i+1] = fmul(cf[RR+3*i+1], req_chan.in_y);
      end
      a_dx_in = gpcm_pkg::sat32(PW'(req_chan.in_x) - PW'(cf[KK+2]));
      a_dy_in = gpcm_pkg::sat32(PW'(req_chan.in_y) - PW'(cf[KK+5]));
   end

   // stage B: camera point, divider operands
   logic                 b_valid_ff, b_p2w_ff, b_bad_in, b_bad_ff;
   logic signed [DW-1:0] b_num0_in, b_num0_ff, b_num1_in, b_num1_ff;
   logic signed [DW-1:0] b_den0_in, b_den0_ff, b_den1_in, b_den1_ff;
   logic signed [DW-1:0] b_c [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         b_c[i] = gpcm_pkg::sat32(a_prod_ff[2*i] + a_prod_ff[2*i+1] + PW'(cf[TT+i]));
      end
      if (a_p2w_ff) begin
         b_num0_in = a_dx_ff;
         b_num1_in = a_dy_ff;
         b_den0_in = cf[KK];
         b_den1_in = cf[KK+4];
         b_bad_in  = (cf[KK] == '0) || (cf[KK+4] == '0);
      end else begin
         b_num0_in = b_c[0];
         b_num1_in = b_c[1];
         b_den0_in = b_c[2];
         b_den1_in = b_c[2];
         b_bad_in  = b_c[2] == '0;
      end
   end

   // first divider pair
   logic signed [DW-1:0] q0, q1;
   logic                 d1_valid, d1_busy;
   logic [1:0]           d1_side;

   gpcm_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock (clock), .en (en), .num (b_num0_ff), .den (b_den0_ff), .quo (q0)
   );

   gpcm_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock (clock), .en (en), .num (b_num1_ff), .den (b_den1_ff), .quo (q1)
   );

   gpcm_delay #(.WIDTH(2), .DEPTH(DIV_LAT)) u_dly1 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b_valid_ff),
      .in_data   ({b_p2w_ff, b_bad_ff}),
      .out_valid (d1_valid),
      .out_data  (d1_side),
      .busy      (d1_busy)
   );

   // stage C: intrinsic products or scale denominator and numerator products
   logic                 c_valid_ff, c_p2w_ff, c_bad_ff;
   logic signed [PW-1:0] c_m_in [4];
   logic signed [PW-1:0] c_m_ff [4];
   logic signed [PW-1:0] c_nm_in [3];
   logic signed [PW-1:0] c_nm_ff [3];
   logic signed [DW-1:0] c_q0_ff, c_q1_ff;

   always_comb begin
      c_m_in[0] = fmul(d1_side[1] ? cf[RI+6] : cf[KK],   q0);
      c_m_in[1] = fmul(d1_side[1] ? cf[RI+7] : cf[KK+1], q1);
      c_m_in[2] = fmul(cf[KK+3], q0);
      c_m_in[3] = fmul(cf[KK+4], q1);
      for (int j = 0; j < 3; j++) begin
         c_nm_in[j] = fmul(cf[RI+6+j], cf[TT+j]);
      end
   end

   // stage D: pixel result or scale operands
   logic                 d_valid_ff, d_p2w_ff, d_bad_in, d_bad_ff;
   logic signed [DW-1:0] d_num_in, d_num_ff, d_den_in, d_den_ff;
   logic signed [DW-1:0] d_x0_in, d_x0_ff, d_x1_in, d_x1_ff;

   always_comb begin
      if (c_p2w_ff) begin
         d_den_in = gpcm_pkg::sat32(c_m_ff[0] + c_m_ff[1] + PW'(cf[RI+8]));
         d_num_in = gpcm_pkg::sat32(c_nm_ff[0] + c_nm_ff[1] + c_nm_ff[2]);
         d_bad_in = c_bad_ff || (d_den_in == '0);
         d_x0_in  = c_q0_ff;
         d_x1_in  = c_q1_ff;
      end else begin
         d_x0_in  = gpcm_pkg::sat32(c_m_ff[0] + c_m_ff[1] + PW'(cf[KK+2]));
         d_x1_in  = gpcm_pkg::sat32(c_m_ff[2] + c_m_ff[3] + PW'(cf[KK+5]));
         d_num_in = d_x0_in;
         d_den_in = DW'(1);
         d_bad_in = c_bad_ff;
      end
   end

   // scale divider
   logic signed [DW-1:0] scale;
   logic                 d2_valid, d2_busy;
   logic [2*DW+1:0]      d2_side;

   gpcm_div #(.FRAC_BITS(FRAC_BITS)) u_div_s (
      .clock (clock), .en (en), .num (d_num_ff), .den (d_den_ff), .quo (scale)
   );

   gpcm_delay #(.WIDTH(2*DW+2), .DEPTH(DIV_LAT)) u_dly2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid_ff),
      .in_data   ({d_p2w_ff, d_bad_ff, d_x0_ff, d_x1_ff}),
      .out_valid (d2_valid),
      .out_data  (d2_side),
      .busy      (d2_busy)
   );

   // stage E: scaled camera point
   logic                 e_valid_ff, e_p2w_ff, e_bad_ff;
   logic signed [DW-1:0] e_x0_ff, e_x1_ff, e_scale_ff;
   logic signed [PW-1:0] e_pr0_in, e_pr0_ff, e_pr1_in, e_pr1_ff;

   always_comb begin
      e_pr0_in = fmul(scale, d2_side[2*DW-1:DW]);
      e_pr1_in = fmul(scale, d2_side[DW-1:0]);
   end

   // stage F: subtract offset
   logic                 f_valid_ff, f_p2w_ff, f_bad_ff;
   logic signed [DW-1:0] f_x0_ff, f_x1_ff;
   logic signed [DW-1:0] f_p_in [3];
   logic signed [DW-1:0] f_p_ff [3];

   always_comb begin
      f_p_in[0] = gpcm_pkg::sat32(e_pr0_ff - PW'(cf[TT]));
      f_p_in[1] = gpcm_pkg::sat32(e_pr1_ff - PW'(cf[TT+1]));
      f_p_in[2] = gpcm_pkg::sat32(PW'(e_scale_ff) - PW'(cf[TT+2]));
   end

   // stage G: inverse rotation products
   logic                 g_valid_ff, g_p2w_ff, g_bad_ff;
   logic signed [DW-1:0] g_x0_ff, g_x1_ff;
   logic signed [PW-1:0] g_m_in [9];
   logic signed [PW-1:0] g_m_ff [9];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            g_m_in[3*i+j] = fmul(cf[RI+3*i+j], f_p_ff[j]);
         end
      end
   end

   // output register
   logic                 rsp_valid_ff, rsp_ok_in, rsp_ok_ff;
   logic signed [DW-1:0] rsp_x_in, rsp_x_ff, rsp_y_in, rsp_y_ff, rsp_z_in, rsp_z_ff;
   logic signed [DW-1:0] g_w [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         g_w[i] = gpcm_pkg::sat32(g_m_ff[3*i] + g_m_ff[3*i+1] + g_m_ff[3*i+2]);
      end
      rsp_ok_in = !g_bad_ff;
      if (g_bad_ff) begin
         rsp_x_in = '0;
         rsp_y_in = '0;
         rsp_z_in = '0;
      end else if (g_p2w_ff) begin
         rsp_x_in = g_w[0];
         rsp_y_in = g_w[1];
         rsp_z_in = g_w[2];
      end else begin
         rsp_x_in = g_x0_ff;
         rsp_y_in = g_x1_ff;
         rsp_z_in = '0;
      end
   end

   assign en   = !rsp_valid_ff || rsp_chan.ready;
   assign busy = a_valid_ff || b_valid_ff || d1_busy || c_valid_ff || d_valid_ff ||
                 d2_busy || e_valid_ff || f_valid_ff || g_valid_ff;

   assign req_chan.ready = en && !((req_chan.mode == gpcm_pkg::MODE_LOAD) && busy);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         f_valid_ff   <= 1'b0;
         g_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= d1_valid;
         d_valid_ff   <= c_valid_ff;
         e_valid_ff   <= d2_valid;
         f_valid_ff   <= e_valid_ff;
         g_valid_ff   <= f_valid_ff;
         rsp_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_p2w_ff  <= a_p2w_in;
         a_prod_ff <= a_prod_in;
         a_dx_ff   <= a_dx_in;
         a_dy_ff   <= a_dy_in;

         b_p2w_ff  <= a_p2w_ff;
         b_bad_ff  <= b_bad_in;
         b_num0_ff <= b_num0_in;
         b_num1_ff <= b_num1_in;
         b_den0_ff <= b_den0_in;
         b_den1_ff <= b_den1_in;

         c_p2w_ff  <= d1_side[1];
         c_bad_ff  <= d1_side[0];
         c_m_ff    <= c_m_in;
         c_nm_ff   <= c_nm_in;
         c_q0_ff   <= q0;
         c_q1_ff   <= q1;

         d_p2w_ff  <= c_p2w_ff;
         d_bad_ff  <= d_bad_in;
         d_num_ff  <= d_num_in;
         d_den_ff  <= d_den_in;
         d_x0_ff   <= d_x0_in;
         d_x1_ff   <= d_x1_in;

         e_p2w_ff   <= d2_side[2*DW+1];
         e_bad_ff   <= d2_side[2*DW];
         e_x0_ff    <= d2_side[2*DW-1:DW];
         e_x1_ff    <= d2_side[DW-1:0];
         e_scale_ff <= scale;
         e_pr0_ff   <= e_pr0_in;
         e_pr1_ff   <= e_pr1_in;

         f_p2w_ff  <= e_p2w_ff;
         f_bad_ff  <= e_bad_ff;
         f_x0_ff   <= e_x0_ff;
         f_x1_ff   <= e_x1_ff;
         f_p_ff    <= f_p_in;

         g_p2w_ff  <= f_p2w_ff;
         g_bad_ff  <= f_bad_ff;
         g_x0_ff   <= f_x0_ff;
         g_x1_ff   <= f_x1_ff;
         g_m_ff    <= g_m_in;

         rsp_x_ff  <= rsp_x_in;
         rsp_y_ff  <= rsp_y_in;
         rsp_z_ff  <= rsp_z_in;
         rsp_ok_ff <= rsp_ok_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.out_x = rsp_x_ff;
   assign rsp_chan.out_y = rsp_y_ff;
   assign rsp_chan.out_z = rsp_z_ff;
   assign rsp_chan.ok    = rsp_ok_ff;

   a_load_when_drained: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.mode == gpcm_pkg::MODE_LOAD)) |-> !busy)
      else $error("load item taken while mapping items in flight");

   a_fail_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_x_ff == '0 && rsp_y_ff == '0 && rsp_z_ff == '0))
      else $error("failed item carries nonzero coordinates");

   a_stall_holds_tail: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(g_valid_ff) && $stable(f_valid_ff))
      else $error("pipeline advanced during stall");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the ground plane camera mapper: loads coefficient sets, maps
// ground points to pixels and pixels to world points, and checks every result
// against a fixed point predictor with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               ok;
   } mapped_point_type;

   localparam logic [1:0] MODE_LOAD = gpcm_pkg::MODE_LOAD;
   localparam logic [1:0] MODE_G2P  = gpcm_pkg::MODE_G2P;
   localparam logic [1:0] MODE_P2W  = gpcm_pkg::MODE_P2W;
   localparam logic [1:0] MODE_NONE = 2'd3;
   localparam int NSLOT   = gpcm_pkg::NSLOT;
   localparam int SLOT_R  = gpcm_pkg::SLOT_R;
   localparam int SLOT_RI = gpcm_pkg::SLOT_RI;
   localparam int SLOT_T  = gpcm_pkg::SLOT_T;
   localparam int SLOT_K  = gpcm_pkg::SLOT_K;
   localparam int FB = 16;
   localparam int DEPTH = 32;
   localparam int LATENCY = 2 * (32 + FB) + 12;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors = 0;
   logic [31:0] coef_shadow [DEPTH];
   mapped_point_type point_queue [$];

   gpcm_req_if req_chan ();
   gpcm_rsp_if rsp_chan ();

   ground_plane_camera_mapper dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.mode = MODE_LOAD;
      req_chan.coef_index = '0;
      req_chan.coef_value = '0;
      req_chan.in_x = '0;
      req_chan.in_y = '0;
      rsp_chan.ready = 1'b0;
   end

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint cf(int i);
      return longint'($signed(coef_shadow[i]));
   endfunction

   function automatic longint qmul(longint a, longint b);
      return (a * b) >>> FB;
   endfunction

   function automatic longint qdiv(longint n, longint d);
      return clip32((n * (64'sd1 << FB)) / d);
   endfunction

   function automatic mapped_point_type project_point(logic [1:0] mode, longint ax,
                                                      longint ay);
      mapped_point_type r;
      longint c[3], p[3], t[3], nx, ny, den, num, sc;
      r = '0;
      for (int i = 0; i < 3; i++) t[i] = cf(SLOT_T + i);
      if (mode == MODE_G2P) begin
         for (int i = 0; i < 3; i++)
            c[i] = clip32(qmul(cf(SLOT_R + 3 * i), ax) + qmul(cf(SLOT_R + 3 * i + 1), ay)
                          + t[i]);
         if (c[2] == 0) return r;
         nx = qdiv(c[0], c[2]);
         ny = qdiv(c[1], c[2]);
         r.x = 32'(clip32(qmul(cf(SLOT_K), nx) + qmul(cf(SLOT_K + 1), ny)
                          + cf(SLOT_K + 2)));
         r.y = 32'(clip32(qmul(cf(SLOT_K + 3), nx) + qmul(cf(SLOT_K + 4), ny)
                          + cf(SLOT_K + 5)));
         r.ok = 1'b1;
         return r;
      end
      if (cf(SLOT_K) == 0 || cf(SLOT_K + 4) == 0) return r;
      c[0] = qdiv(clip32(ax - cf(SLOT_K + 2)), cf(SLOT_K));
      c[1] = qdiv(clip32(ay - cf(SLOT_K + 5)), cf(SLOT_K + 4));
      c[2] = 64'sd1 << FB;
      den = 0;
      num = 0;
      for (int i = 0; i < 3; i++) begin
         den += qmul(cf(SLOT_RI + 6 + i), c[i]);
         num += qmul(cf(SLOT_RI + 6 + i), t[i]);
      end
      den = clip32(den);
      num = clip32(num);
      if (den == 0) return r;
      sc = qdiv(num, den);
      for (int i = 0; i < 3; i++) p[i] = clip32(qmul(sc, c[i]) - t[i]);
      r.x = 32'(clip32(qmul(cf(SLOT_RI), p[0]) + qmul(cf(SLOT_RI + 1), p[1])
                       + qmul(cf(SLOT_RI + 2), p[2])));
      r.y = 32'(clip32(qmul(cf(SLOT_RI + 3), p[0]) + qmul(cf(SLOT_RI + 4), p[1])
                       + qmul(cf(SLOT_RI + 5), p[2])));
      r.z = 32'(clip32(qmul(cf(SLOT_RI + 6), p[0]) + qmul(cf(SLOT_RI + 7), p[1])
                       + qmul(cf(SLOT_RI + 8), p[2])));
      r.ok = 1'b1;
      return r;
   endfunction

   task automatic send_item(logic [1:0] mode, logic [4:0] idx, logic [31:0] val,
                            logic [31:0] ax, logic [31:0] ay);
      int gap;
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode <= mode;
      req_chan.coef_index <= idx;
      req_chan.coef_value <= val;
      req_chan.in_x <= ax;
      req_chan.in_y <= ay;
      do @(posedge clock); while (!req_chan.ready);
      if (mode == MODE_LOAD) coef_shadow[idx] = val;
      else if (mode != MODE_NONE)
         point_queue = {point_queue, project_point(mode, longint'($signed(ax)),
                                                   longint'($signed(ay)))};
   endtask

   task automatic drain;
      req_chan.valid <= 1'b0;
      while (point_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 65536 * 4) - 32'd131072;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rand_coord();
      if ($urandom_range(0, 7) == 0) return rand_word();
      return 32'($signed($urandom_range(0, 2000 * 65536)) - 1000 * 65536);
   endfunction

   task automatic load_camera(bit noisy);
      logic [31:0] v;
      for (int i = 0; i < NSLOT; i++) begin
         v = noisy ? rand_word()
                   : 32'($signed($urandom_range(0, 4 * 65536)) - 2 * 65536);
         if (!noisy && (i == SLOT_K || i == SLOT_K + 4))
            v = 32'($urandom_range(100, 1500)) << FB;
         if (!noisy && i == SLOT_T + 2) v = 32'($urandom_range(1, 20)) << FB;
         send_item(MODE_LOAD, 5'(i), v, rand_word(), rand_word());
      end
   endtask

   task automatic test_zero_store;
      send_item(MODE_G2P, '0, '0, 32'h7fff_ffff, 32'h8000_0000);
      send_item(MODE_P2W, '0, '0, 32'h8000_0000, 32'h7fff_ffff);
      drain();
   endtask

   task automatic test_directed;
      for (int i = 0; i < NSLOT; i++) send_item(MODE_LOAD, 5'(i), '0, '0, '0);
      send_item(MODE_LOAD, 5'(SLOT_R), 32'h0001_0000, '0, '0);
      send_item(MODE_LOAD, 5'(SLOT_R + 4), 32'h0001_0000, '0, '0);
      send_item(MODE_LOAD, 5'(SLOT_T + 2), 32'h000a_0000, '0, '0);
      send_item(MODE_LOAD, 5'(SLOT_K), 32'h0200_0000, '0, '0);
      send_item(MODE_LOAD, 5'(SLOT_K + 1), 32'h8000_0000, '0, '0);
      send_item(MODE_LOAD, 5'(SLOT_K + 4), 32'h7fff_ffff, '0, '0);
      send_item(MODE_LOAD, 5'd31, 32'hffff_ffff, '0, '0);
      send_item(MODE_G2P, '0, '0, 32'h0003_0000, 32'hfffe_0000);
      send_item(MODE_G2P, '0, '0, 32'h7fff_ffff, 32'h8000_0000);
      send_item(MODE_NONE, 5'd31, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      // scale denominator zero: inverse rotation row 2 cleared
      send_item(MODE_P2W, '0, '0, 32'h0010_0000, 32'h0020_0000);
      send_item(MODE_LOAD, 5'(SLOT_RI + 8), 32'h0001_0000, '0, '0);
      send_item(MODE_LOAD, 5'(SLOT_RI), 32'h8000_0000, '0, '0);
      send_item(MODE_P2W, '0, '0, 32'h8000_0000, 32'h7fff_ffff);
      send_item(MODE_LOAD, 5'(SLOT_K + 4), '0, '0, '0);
      send_item(MODE_P2W, '0, '0, 32'h0001_0000, 32'h0001_0000);
      send_item(MODE_LOAD, 5'(SLOT_T + 2), 32'hfff6_0000, '0, '0);
      send_item(MODE_LOAD, 5'(SLOT_R + 8), '0, '0, '0);
      send_item(MODE_G2P, '0, '0, 32'h0001_0000, 32'h0001_0000);
      drain();
   endtask

   task automatic test_random;
      logic [1:0] m;
      for (int s = 0; s < 10; s++) begin
         load_camera(s % 4 == 3);
         for (int n = 0; n < 63; n++) begin
            m = ($urandom_range(0, 1) == 0) ? MODE_G2P : MODE_P2W;
            if ($urandom_range(0, 30) == 0) m = MODE_NONE;
            send_item(m, 5'($urandom), $urandom, rand_coord(), rand_coord());
         end
         drain();
      end
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) coef_shadow[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_zero_store();
      test_directed();
      test_random();
      if (errors == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

   initial begin
      int wait_cycles;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         wait_cycles = $urandom_range(0, 13);
         if ($urandom_range(0, 2) == 0) wait_cycles = 0;
         if (wait_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   always @(posedge clock) begin
      mapped_point_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (point_queue.size() == 0) begin
            errors++;
            $display("%0t: unexpected result x=%h y=%h z=%h ok=%b", $time,
                     rsp_chan.out_x, rsp_chan.out_y, rsp_chan.out_z, rsp_chan.ok);
         end else begin
            want = point_queue.pop_front();
            if (want.x !== rsp_chan.out_x || want.y !== rsp_chan.out_y ||
                want.z !== rsp_chan.out_z || want.ok !== rsp_chan.ok) begin
               errors++;
               $display("%0t: expected x=%h y=%h z=%h ok=%b, got x=%h y=%h z=%h ok=%b",
                        $time, want.x, want.y, want.z, want.ok, rsp_chan.out_x,
                        rsp_chan.out_y, rsp_chan.out_z, rsp_chan.ok);
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("tb_top: errors");
      $finish;
   end

endmodule
